// ===== hdl/infix_expression_evaluator_macros.svh =====
// assertion macros used by the evaluator datapath
// needs clk and rst in the scope of each use
`ifndef INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// same-cycle implication
`define IEE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IEE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/iee_pkg.sv =====
// shared constants and controller/datapath handshake types for the evaluator
// no dependencies
`timescale 1ns / 1ps

package iee_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_OPER  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_OPEN  = 3'd4;
  localparam logic [2:0] OP_CLOSE = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_PAREN = 3'd2;
  localparam logic [2:0] ST_OVER  = 3'd3;
  localparam logic [2:0] ST_DIV0  = 3'd4;
  localparam logic [2:0] ST_LEFT  = 3'd5;

  typedef struct packed {
    logic       load_tok;
    logic       push_tok_val;
    logic       push_tok_op;
    logic       pop_op;
    logic       rd_op;
    logic       rd_top;
    logic       rd_second;
    logic       rd_base;
    logic       latch_b;
    logic       latch_a;
    logic       pop_two;
    logic       alu_add;
    logic       start_iter;
    logic       latch_iter;
    logic       push_res;
    logic       set_err;
    logic [2:0] err_code;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic       err_set;
    logic       ocnt_zero;
    logic       vcnt_lt2;
    logic [1:0] tok_kind;
    logic [2:0] tok_op;
    logic [2:0] top_op;
    logic       b_zero;
    logic       iter_done;
    logic       out_valid;
  } sts_t;

endpackage

// ===== hdl/iee_muldiv.sv =====
// shared iterative unit: shift-add multiply and restoring signed divide
// depends on nothing but its parameter
`timescale 1ns / 1ps

module iee_muldiv #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   is_div,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] res
);

  localparam int W   = VALUE_WIDTH;
  localparam int CNW = $clog2(W);

  logic           busy;
  logic [CNW-1:0] cnt;
  logic           mode_div;
  logic           neg;
  logic [W-1:0]   rem;
  logic [W-1:0]   quo;
  logic [W-1:0]   dvs;
  logic [W:0]     sh;
  logic [W:0]     diff;

  assign sh   = {rem, quo[W-1]};
  assign diff = sh - {1'b0, dvs};
  assign res  = mode_div ? (neg ? W'(-quo) : quo) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= '0;
      mode_div <= is_div;
      neg      <= a[W-1] ^ b[W-1];
      rem      <= '0;
      if (is_div) begin
        quo <= a[W-1] ? W'(-a) : a;
        dvs <= b[W-1] ? W'(-b) : b;
      end else begin
        quo <= b;
        dvs <= a;
      end
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (mode_div) begin
        if (!diff[W]) begin
          rem <= diff[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= sh[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end
      end else begin
        if (quo[0]) begin
          rem <= rem + dvs;
        end
        dvs <= {dvs[W-2:0], 1'b0};
        quo <= {1'b0, quo[W-1:1]};
      end
    end
  end

endmodule

// ===== hdl/iee_datapath.sv =====
// datapath: token register, value and operator stacks, error latch, result register
// depends on iee_pkg, iee_muldiv and the assertion macros
`timescale 1ns / 1ps
`include "infix_expression_evaluator_macros.svh"

module iee_datapath #(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   tok_kind_in,
  input  logic [31:0]  tok_val_in,
  input  logic [2:0]   tok_op_in,
  input  iee_pkg::cmd_t cmd,
  output iee_pkg::sts_t sts,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [31:0]  out_value,
  output logic [2:0]   out_status
);
  import iee_pkg::*;

  localparam int D  = STACK_DEPTH;
  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(D);
  localparam int CW = $clog2(D + 1);

  logic [W-1:0]  vmem [D];
  logic [2:0]    omem [D];
  logic [W-1:0]  vrd;
  logic [2:0]    ord;
  logic [CW-1:0] vcnt;
  logic [CW-1:0] ocnt;
  logic [2:0]    err;
  logic [1:0]    tok_kind;
  logic [31:0]   tok_val;
  logic [2:0]    tok_op;
  logic [W-1:0]  a;
  logic [W-1:0]  b;
  logic [W-1:0]  res;
  logic [W-1:0]  tok_ext;
  logic [W-1:0]  unit_res;
  logic          unit_done;
  logic [AW-1:0] vra;
  logic          vfull;
  logic          ofull;

  assign tok_ext = W'($signed(tok_val));
  assign vfull   = (vcnt == CW'(D));
  assign ofull   = (ocnt == CW'(D));

  always_comb begin
    if (cmd.rd_top) begin
      vra = AW'(vcnt - 1'b1);
    end else if (cmd.rd_second) begin
      vra = AW'(vcnt - 2'd2);
    end else begin
      vra = '0;
    end
  end

  iee_muldiv #(.VALUE_WIDTH(W)) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.start_iter),
    .is_div (ord == OP_DIV),
    .a      (a),
    .b      (b),
    .done   (unit_done),
    .res    (unit_res)
  );

  // stacks
  always_ff @(posedge clk) begin
    if (err == ST_OK && !vfull && cmd.push_tok_val) begin
      vmem[AW'(vcnt)] <= tok_ext;
    end else if (err == ST_OK && !vfull && cmd.push_res) begin
      vmem[AW'(vcnt)] <= res;
    end
    vrd <= vmem[vra];
  end

  always_ff @(posedge clk) begin
    if (err == ST_OK && !ofull && cmd.push_tok_op) begin
      omem[AW'(ocnt)] <= tok_op;
    end
    if (cmd.rd_op) begin
      ord <= omem[AW'(ocnt - 1'b1)];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_tok) begin
      tok_kind <= tok_kind_in;
      tok_val  <= tok_val_in;
      tok_op   <= tok_op_in;
    end
    if (cmd.latch_b) b <= vrd;
    if (cmd.latch_a) a <= vrd;
    if (cmd.alu_add) begin
      res <= (ord == OP_SUB) ? a - b : a + b;
    end else if (cmd.latch_iter) begin
      res <= unit_res;
    end
    if (cmd.finish) begin
      if (err != ST_OK) begin
        out_status <= err;
        out_value  <= '0;
      end else if (vcnt == '0) begin
        out_status <= ST_UNDER;
        out_value  <= '0;
      end else if (vcnt > CW'(1)) begin
        out_status <= ST_LEFT;
        out_value  <= '0;
      end else begin
        out_status <= ST_OK;
        out_value  <= 32'($signed(vrd));
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt      <= '0;
      ocnt      <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (err == ST_OK && (cmd.push_tok_val || cmd.push_res)) begin
        if (vfull) err <= ST_OVER;
        else vcnt <= vcnt + 1'b1;
      end
      if (err == ST_OK && cmd.push_tok_op) begin
        if (ofull) err <= ST_OVER;
        else ocnt <= ocnt + 1'b1;
      end
      if (cmd.pop_op)  ocnt <= ocnt - 1'b1;
      if (cmd.pop_two) vcnt <= vcnt - 2'd2;
      if (cmd.set_err && err == ST_OK) err <= cmd.err_code;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        vcnt      <= '0;
        ocnt      <= '0;
        err       <= ST_OK;
      end
    end
  end

  always_comb begin
    sts.err_set   = (err != ST_OK);
    sts.ocnt_zero = (ocnt == '0);
    sts.vcnt_lt2  = (vcnt < CW'(2));
    sts.tok_kind  = tok_kind;
    sts.tok_op    = tok_op;
    sts.top_op    = ord;
    sts.b_zero    = (b == '0);
    sts.iter_done = unit_done;
    sts.out_valid = out_valid;
  end

  `IEE_ASSERT_NXT(a_finish_clears, cmd.finish, vcnt == '0 && ocnt == '0 && err == ST_OK && out_valid, "end of line left state behind")
  `IEE_ASSERT_IMP(a_count_bound, 1'b1, vcnt <= CW'(D) && ocnt <= CW'(D), "stack count beyond depth")
  `IEE_ASSERT_NXT(a_err_sticky, err != ST_OK && !cmd.finish, $stable(err), "latched error changed")

endmodule

// ===== hdl/iee_ctrl.sv =====
// controller: token dispatch and reduction sequencing for the evaluator
// depends on iee_pkg
`timescale 1ns / 1ps

module iee_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  iee_pkg::sts_t sts,
  output iee_pkg::cmd_t cmd
);
  import iee_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RDOP  = 4'd2;
  localparam logic [3:0] S_OPCHK = 4'd3;
  localparam logic [3:0] S_POP   = 4'd4;
  localparam logic [3:0] S_GETB  = 4'd5;
  localparam logic [3:0] S_GETA  = 4'd6;
  localparam logic [3:0] S_EXEC  = 4'd7;
  localparam logic [3:0] S_ITER  = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;
  localparam logic [3:0] S_TAIL  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       cont;

  assign in_ready = (state == S_IDLE);

  // reduce while top op binds at least as tight, to ( on ), all on end
  always_comb begin
    if (sts.tok_kind == KIND_END) begin
      cont = 1'b1;
    end else if (sts.tok_op == OP_CLOSE) begin
      cont = (sts.top_op != OP_OPEN);
    end else if (sts.tok_op inside {OP_ADD, OP_SUB}) begin
      cont = (sts.top_op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV});
    end else begin
      cont = (sts.top_op inside {OP_MUL, OP_DIV});
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load_tok = in_valid && in_ready;
    state_next   = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) state_next = S_DISP;
      end
      S_DISP: begin
        state_next = S_IDLE;
        case (sts.tok_kind)
          KIND_VALUE: cmd.push_tok_val = 1'b1;
          KIND_OPER: begin
            if (!sts.err_set) begin
              if (sts.tok_op == OP_OPEN) begin
                cmd.push_tok_op = 1'b1;
              end else if (sts.tok_op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CLOSE}) begin
                state_next = S_RDOP;
              end
            end
          end
          KIND_END: state_next = S_RDOP;
          default: state_next = S_IDLE;
        endcase
      end
      S_RDOP: begin
        if (sts.err_set || sts.ocnt_zero) begin
          state_next = S_TAIL;
        end else begin
          cmd.rd_op  = 1'b1;
          state_next = S_OPCHK;
        end
      end
      S_OPCHK: begin
        if (sts.tok_kind == KIND_END && sts.top_op == OP_OPEN) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_PAREN;
          state_next   = S_TAIL;
        end else if (cont) begin
          state_next = S_POP;
        end else begin
          state_next = S_TAIL;
        end
      end
      S_POP: begin
        cmd.pop_op = 1'b1;
        if (sts.vcnt_lt2) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_UNDER;
          state_next   = S_RDOP;
        end else begin
          cmd.rd_top = 1'b1;
          state_next = S_GETB;
        end
      end
      S_GETB: begin
        cmd.latch_b   = 1'b1;
        cmd.rd_second = 1'b1;
        state_next    = S_GETA;
      end
      S_GETA: begin
        cmd.latch_a = 1'b1;
        cmd.pop_two = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        case (sts.top_op)
          OP_ADD, OP_SUB: begin
            cmd.alu_add = 1'b1;
            state_next  = S_PUSH;
          end
          OP_MUL: begin
            cmd.start_iter = 1'b1;
            state_next     = S_ITER;
          end
          OP_DIV: begin
            if (sts.b_zero) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_DIV0;
              state_next   = S_RDOP;
            end else begin
              cmd.start_iter = 1'b1;
              state_next     = S_ITER;
            end
          end
          default: begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_PAREN;
            state_next   = S_RDOP;
          end
        endcase
      end
      S_ITER: begin
        if (sts.iter_done) begin
          cmd.latch_iter = 1'b1;
          state_next     = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push_res = 1'b1;
        state_next   = S_RDOP;
      end
      S_TAIL: begin
        state_next = S_IDLE;
        if (sts.tok_kind == KIND_END) begin
          cmd.rd_base = 1'b1;
          state_next  = S_FIN;
        end else if (sts.tok_op == OP_CLOSE) begin
          if (!sts.err_set) begin
            if (sts.ocnt_zero) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_PAREN;
            end else begin
              cmd.pop_op = 1'b1;
            end
          end
        end else begin
          cmd.push_tok_op = 1'b1;
        end
      end
      S_FIN: begin
        // wait here while the previous result is still held
        if (!sts.out_valid) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/infix_expression_evaluator.sv =====
// channel  dir  handshake          tdata                                  tuser
// s        in   s_tvalid/s_tready  [31:0] operand_value [34:32] operator  [1:0] req_type
// m        out  m_tvalid/m_tready  [31:0] result_value                    [2:0] status
//
// value tokens and open parentheses are pushed at dispatch; other operator tokens pass
// through the reduction loop, where an add or subtract reduction uses the adder and a
// multiply or divide uses the shared shift-add / restoring divide unit
// an end token also runs the loop, then loads the result register; it waits while the
// previous result has not been taken, and no new token is accepted meanwhile
// rst is synchronous and clears counts, error latch and the result valid flag
`timescale 1ns / 1ps

module infix_expression_evaluator #(
  parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // operand_value, operator_code, zero pad
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value
  output logic [2:0]  m_tuser    // status
);
  import iee_pkg::*;

  cmd_t cmd;
  sts_t sts;

  iee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iee_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .tok_kind_in (s_tuser),
    .tok_val_in  (s_tdata[31:0]),
    .tok_op_in   (s_tdata[34:32]),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_value   (m_tdata),
    .out_status  (m_tuser)
  );

endmodule
